>>> src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("assertion failed");

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> src/twce_pkg.sv
`default_nettype none

package twce_pkg;

	localparam int DEF_MAX_COLS = 128;
	localparam int DEF_MAX_ROWS = 32;

	localparam int KIND_W      = 4;
	localparam int CHAR_W      = 8;
	localparam int COL_W       = 7;
	localparam int ROW_W       = 5;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 48;

	localparam int COLS_W     = 8;
	localparam int ROWS_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL  = 2'd2;

	localparam logic [COLS_W-1:0] COLS_RST   = 8'd80;
	localparam logic [ROWS_W-1:0] ROWS_RST   = 6'd30;
	localparam logic              SCROLL_RST = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;
	localparam int                TAB_STEP   = 8;

	typedef enum logic [KIND_W-1:0] {
		K_CHAR    = 4'd0,
		K_TAB     = 4'd1,
		K_LEFT    = 4'd2,
		K_RIGHT   = 4'd3,
		K_UP      = 4'd4,
		K_DOWN    = 4'd5,
		K_PGUP    = 4'd6,
		K_PGDN    = 4'd7,
		K_HOME    = 4'd8,
		K_END     = 4'd9,
		K_BKSP    = 4'd10,
		K_NEWLINE = 4'd11,
		K_CLEAR   = 4'd12,
		K_READ    = 4'd13
	} kind_t;

	typedef enum logic [2:0] {
		SW_NONE,
		SW_INIT,
		SW_FILL,
		SW_SCROLL,
		SW_BLANK
	} sweep_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLAMP,
		ST_EXEC,
		ST_FILL,
		ST_SCROLL,
		ST_DRAIN,
		ST_BLANK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic   load;
		logic   clamp;
		logic   exec;
		logic   finish;
		sweep_t sweep;
	} cmd_t;

	typedef struct packed {
		logic init_last;
		logic fill_last;
		logic scroll_last;
		logic blank_last;
		logic go_fill;
		logic go_scroll;
		logic row_one;
	} status_t;

	// Two thirds of the height, rounded down: 2h/3 as a multiply by 342/512.
	function automatic logic [7:0] page_of(input logic [7:0] h);
		logic [16:0] p;
		p = {9'd0, h} * 17'd342;
		return p[16:9];
	endfunction

endpackage

`default_nettype wire

>>> src/twce_ram.sv
`default_nettype none

module twce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/twce_ctrl.sv
`default_nettype none

module twce_ctrl import twce_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output      logic    s_tready,
	output      logic    m_tvalid,
	input  wire logic    m_tready,
	output      cmd_t    cmd,
	input  wire status_t status
);

	state_t state_q, state_d;
	logic   m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.sweep  = SW_NONE;
		s_tready   = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = SW_INIT;
				if (status.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_CLAMP;
				end
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (status.go_fill) begin
					state_d = ST_FILL;
				end else if (status.go_scroll) begin
					state_d = status.row_one ? ST_BLANK : ST_SCROLL;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_FILL: begin
				cmd.sweep = SW_FILL;
				if (status.fill_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_SCROLL: begin
				cmd.sweep = SW_SCROLL;
				if (status.scroll_last) begin
					state_d = ST_DRAIN;
				end
			end
			// The last copied cell is written here, before the bottom row is blanked.
			ST_DRAIN: begin
				state_d = ST_BLANK;
			end
			ST_BLANK: begin
				cmd.sweep = SW_BLANK;
				if (status.blank_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

`default_nettype wire

>>> src/twce_dp.sv
`default_nettype none

module twce_dp import twce_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [KIND_W-1:0]      s_tuser,
	output      logic [OUT_TDATA_W-1:0] m_tdata,
	input  wire cmd_t                   cmd,
	output      status_t                status
);

	localparam int CXW   = $clog2(MAX_COLS);
	localparam int RYW   = $clog2(MAX_ROWS);
	localparam int WW    = $clog2(MAX_COLS + 1);
	localparam int HW    = $clog2(MAX_ROWS + 1);
	localparam int XEW   = WW + 1;
	localparam int YEW   = HW + 1;
	localparam int AW    = CXW + RYW;
	localparam int DEPTH = MAX_ROWS * (1 << CXW);

	// Configuration registers.
	logic [COLS_W-1:0] columns_q;
	logic [ROWS_W-1:0] rows_q;
	logic              scroll_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q     <= COLS_RST;
			rows_q        <= ROWS_RST;
			scroll_mode_q <= SCROLL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMNS: columns_q     <= cfg_data[COLS_W-1:0];
				CFG_ROWS:    rows_q        <= cfg_data[ROWS_W-1:0];
				CFG_SCROLL:  scroll_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Window size as used: zero acts as one, oversize saturates to the store.
	logic [WW-1:0] eff_w;
	logic [HW-1:0] eff_h;

	always_comb begin
		if (columns_q == '0) begin
			eff_w = WW'(1);
		end else if (int'(columns_q) > MAX_COLS) begin
			eff_w = WW'(MAX_COLS);
		end else begin
			eff_w = WW'(columns_q);
		end
		if (rows_q == '0) begin
			eff_h = HW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			eff_h = HW'(MAX_ROWS);
		end else begin
			eff_h = HW'(rows_q);
		end
	end

	// Request fields.
	logic [KIND_W-1:0] kind_q;
	logic [CHAR_W-1:0] ch_q;
	logic [COL_W-1:0]  rc_q;
	logic [ROW_W-1:0]  rr_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= s_tuser;
			ch_q   <= s_tdata[7:0];
			rc_q   <= s_tdata[14:8];
			rr_q   <= s_tdata[19:15];
		end
	end

	logic [WW-1:0]  w_q;
	logic [HW-1:0]  h_q;
	logic [HW-1:0]  page_q;
	logic [CXW-1:0] cx_q;
	logic [RYW-1:0] cy_q;

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			w_q    <= eff_w;
			h_q    <= eff_h;
			page_q <= HW'(page_of(8'(eff_h)));
		end
	end

	// Cursor step logic.
	logic [XEW-1:0] xe, we_w, tab_x;
	logic [YEW-1:0] ye, he, sum_up, sum_dn;
	logic [CXW-1:0] nx_x, wcol;
	logic [RYW-1:0] nx_y, wrow;
	logic [CHAR_W-1:0] wch;
	logic ex_wr, ex_nl, ex_fill, ex_scroll, ex_clr, ex_scr, ex_rd;

	assign xe     = XEW'(cx_q);
	assign we_w   = XEW'(w_q);
	assign ye     = YEW'(cy_q);
	assign he     = YEW'(h_q);
	assign tab_x  = (xe + XEW'(TAB_STEP)) & ~XEW'(TAB_STEP - 1);
	assign sum_up = ye + he - YEW'(page_q);
	assign sum_dn = ye + YEW'(page_q);

	always_comb begin
		nx_x      = cx_q;
		nx_y      = cy_q;
		wcol      = cx_q;
		wrow      = cy_q;
		wch       = ch_q;
		ex_wr     = 1'b0;
		ex_nl     = 1'b0;
		ex_fill   = 1'b0;
		ex_scroll = 1'b0;
		ex_clr    = 1'b0;
		ex_scr    = 1'b0;
		ex_rd     = 1'b0;
		case (kind_q)
			K_CHAR: begin
				if (ch_q >= CHAR_SPACE && ch_q <= CHAR_LAST) begin
					ex_wr = 1'b1;
					if (xe + XEW'(1) == we_w) begin
						ex_nl = 1'b1;
					end else begin
						nx_x = CXW'(xe + XEW'(1));
					end
				end
			end
			K_TAB: begin
				if (tab_x >= we_w) begin
					ex_nl = 1'b1;
				end else begin
					nx_x = CXW'(tab_x);
				end
			end
			K_LEFT: begin
				nx_x = (cx_q == '0) ? CXW'(we_w - XEW'(1)) : CXW'(xe - XEW'(1));
			end
			K_RIGHT: begin
				nx_x = (xe + XEW'(1) == we_w) ? '0 : CXW'(xe + XEW'(1));
			end
			K_UP: begin
				nx_y = (cy_q == '0) ? RYW'(he - YEW'(1)) : RYW'(ye - YEW'(1));
			end
			K_DOWN: begin
				nx_y = (ye + YEW'(1) == he) ? '0 : RYW'(ye + YEW'(1));
			end
			K_PGUP: begin
				nx_y = (sum_up >= he) ? RYW'(sum_up - he) : RYW'(sum_up);
			end
			K_PGDN: begin
				nx_y = (sum_dn >= he) ? RYW'(sum_dn - he) : RYW'(sum_dn);
			end
			K_HOME: begin
				nx_x = '0;
			end
			K_END: begin
				nx_x = CXW'(we_w - XEW'(1));
			end
			K_BKSP: begin
				if (cx_q != '0) begin
					nx_x  = CXW'(xe - XEW'(1));
					wcol  = CXW'(xe - XEW'(1));
					wch   = CHAR_SPACE;
					ex_wr = 1'b1;
				end else if (cy_q != '0) begin
					nx_x  = CXW'(we_w - XEW'(1));
					nx_y  = RYW'(ye - YEW'(1));
					wcol  = CXW'(we_w - XEW'(1));
					wrow  = RYW'(ye - YEW'(1));
					wch   = CHAR_SPACE;
					ex_wr = 1'b1;
				end
			end
			K_NEWLINE: begin
				ex_nl = 1'b1;
			end
			K_CLEAR: begin
				ex_fill = 1'b1;
				ex_clr  = 1'b1;
			end
			K_READ: begin
				ex_rd = (int'(rc_q) < MAX_COLS) && (int'(rr_q) < MAX_ROWS);
			end
			default: ;
		endcase
		if (ex_nl) begin
			nx_x = '0;
			if (ye + YEW'(1) < he) begin
				nx_y = RYW'(ye + YEW'(1));
			end else if (!scroll_mode_q) begin
				nx_y    = '0;
				ex_fill = 1'b1;
				ex_clr  = 1'b1;
			end else begin
				nx_y      = RYW'(he - YEW'(1));
				ex_scroll = 1'b1;
				ex_scr    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0;
			cy_q <= '0;
		end else if (cmd.clamp) begin
			if (XEW'(cx_q) >= XEW'(eff_w)) begin
				cx_q <= CXW'(eff_w - WW'(1));
			end
			if (YEW'(cy_q) >= YEW'(eff_h)) begin
				cy_q <= RYW'(eff_h - HW'(1));
			end
		end else if (cmd.exec) begin
			cx_q <= nx_x;
			cy_q <= nx_y;
		end
	end

	// Result fields gathered while the item runs.
	logic              res_written_q, res_cleared_q, res_scrolled_q, rd_ok_q;
	logic [CXW-1:0]    res_wc_q;
	logic [RYW-1:0]    res_wr_q;
	logic [CHAR_W-1:0] res_wch_q;

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_written_q  <= ex_wr;
			res_wc_q       <= ex_wr ? wcol : '0;
			res_wr_q       <= ex_wr ? wrow : '0;
			res_wch_q      <= ex_wr ? wch : '0;
			res_cleared_q  <= ex_clr;
			res_scrolled_q <= ex_scr;
			rd_ok_q        <= ex_rd;
		end
	end

	// Sweep counters for clear, scroll and the clearing pass after reset.
	logic [AW-1:0]  clr_q;
	logic [CXW-1:0] sx_q;
	logic [RYW-1:0] sy_q;
	logic           sx_last;

	assign sx_last = (XEW'(sx_q) + XEW'(1) == we_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else begin
			if (cmd.sweep == SW_INIT) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.exec) begin
				sx_q <= '0;
				sy_q <= '0;
			end else if (cmd.sweep == SW_FILL || cmd.sweep == SW_SCROLL ||
					cmd.sweep == SW_BLANK) begin
				if (sx_last) begin
					sx_q <= '0;
					sy_q <= sy_q + RYW'(1);
				end else begin
					sx_q <= sx_q + CXW'(1);
				end
			end
		end
	end

	assign status.init_last   = (clr_q == AW'(DEPTH - 1));
	assign status.fill_last   = sx_last && (YEW'(sy_q) + YEW'(1) == he);
	assign status.scroll_last = sx_last && (YEW'(sy_q) + YEW'(2) == he);
	assign status.blank_last  = sx_last;
	assign status.go_fill     = ex_fill;
	assign status.go_scroll   = ex_scroll;
	assign status.row_one     = (h_q == HW'(1));

	// Character store. A scroll reads the row below and writes a nonzero copy in the next cycle.
	logic              pend_s1;
	logic [AW-1:0]     pend_addr_s1;
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [CHAR_W-1:0] ram_wdata, ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= (cmd.sweep == SW_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		pend_addr_s1 <= {sy_q, sx_q};
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {wrow, wcol};
		ram_wdata = wch;
		ram_re    = 1'b0;
		ram_raddr = {RYW'(rr_q), CXW'(rc_q)};
		if (cmd.sweep == SW_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (pend_s1) begin
			ram_we    = (ram_rdata != '0);
			ram_waddr = pend_addr_s1;
			ram_wdata = ram_rdata;
		end else if (cmd.sweep == SW_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = {sy_q, sx_q};
			ram_wdata = CHAR_SPACE;
		end else if (cmd.sweep == SW_BLANK) begin
			ram_we    = 1'b1;
			ram_waddr = {RYW'(he - YEW'(1)), sx_q};
			ram_wdata = CHAR_SPACE;
		end else if (cmd.exec) begin
			ram_we = ex_wr;
		end
		if (cmd.sweep == SW_SCROLL) begin
			ram_re    = 1'b1;
			ram_raddr = {sy_q + RYW'(1), sx_q};
		end else if (cmd.exec) begin
			ram_re = ex_rd;
		end
	end

	twce_ram #(
		.WIDTH(CHAR_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Output register.
	logic [OUT_TDATA_W-1:0] tdata_q;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			tdata_q <= {5'd0,
				rd_ok_q ? ram_rdata : 8'd0,
				res_scrolled_q,
				res_cleared_q,
				res_wch_q,
				ROW_W'(res_wr_q),
				COL_W'(res_wc_q),
				res_written_q,
				ROW_W'(cy_q),
				COL_W'(cx_q)};
		end
	end

	assign m_tdata = tdata_q;

endmodule

`default_nettype wire

>>> src/text_window_cursor_engine.sv
// A request passes the clamp, exec and finish states; s_tready stays low until it is back in idle.
// Clear, and newline at the bottom in clear mode, sweep every window cell, one cell a cycle.
// Scroll shifts the rows up by one and blanks the bottom row (the blank alone for a single row).
// A request is taken while an earlier result still waits in the output register.
// Reset is asynchronous; afterwards the store is zeroed one cell a cycle, all
// MAX_ROWS * 2**ceil(log2(MAX_COLS)) cells (4096 by default), with s_tready low.
`default_nettype none

`include "assert_macros.svh"

module text_window_cursor_engine import twce_pkg::*; #(
	parameter int MAX_COLS = DEF_MAX_COLS,
	parameter int MAX_ROWS = DEF_MAX_ROWS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   s_tvalid,
	output      logic                   s_tready,
	// char_code[7:0], read_col[14:8], read_row[19:15], zero[23:20]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// kind[3:0]
	input  wire logic [KIND_W-1:0]      s_tuser,
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	// cursor_col[6:0], cursor_row[11:7], cell_written[12], write_col[19:13],
	// write_row[24:20], write_char[32:25], screen_cleared[33],
	// screen_scrolled[34], read_data[42:35], zero[47:43]
	output      logic [OUT_TDATA_W-1:0] m_tdata
);

	cmd_t    cmd;
	status_t status;

	twce_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.status  (status)
	);

	twce_dp #(
		.MAX_COLS(MAX_COLS),
		.MAX_ROWS(MAX_ROWS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.status   (status)
	);

	// No request is taken while the store is being swept.
	`ASSERT_NEVER(a_no_accept_in_sweep, clk, arst_n, cmd.sweep != SW_NONE && s_tready)
	// An accepted request is clamped in the following cycle.
	`ASSERT_AT(a_accept_then_clamp, clk, arst_n, (s_tvalid && s_tready) |=> cmd.clamp)
	// A result is only loaded into a free or draining output register.
	`ASSERT_AT(a_finish_free, clk, arst_n, cmd.finish |-> (!m_tvalid || m_tready))
	// A loaded result is offered in the next cycle.
	`ASSERT_AT(a_finish_valid, clk, arst_n, cmd.finish |=> m_tvalid)

endmodule

`default_nettype wire
